// ----- rtl/frb_pkg.sv -----
// Shared types and constants for the fragment reassembly buffer.
// No dependencies; imported by every module of the block.
package frb_pkg;

    localparam int WORD_BYTES = 8;    // bytes per readout word and number of lanes
    localparam int LEN_W      = 10;   // message length width
    localparam int IDX_W      = 6;    // word index width
    localparam int READ_LIMIT = 512;  // hard ceiling on a stored message

    // Result kinds carried on m_tuser
    typedef enum logic [1:0] {
        STATUS_PENDING  = 2'd0,
        STATUS_COMPLETE = 2'd1,
        STATUS_DROPPED  = 2'd2
    } status_t;

    // Readout sequencer
    typedef enum logic [1:0] {
        RS_ACCEPT,
        RS_ADDR,
        RS_DATA
    } rd_state_t;

    // Outcome of one fragment, from the control unit
    typedef struct packed {
        status_t            status;
        logic [LEN_W-1:0]   msg_len;
        logic [IDX_W-1:0]   last_idx;
    } frag_res_t;

    // Lane write request for one fragment
    typedef struct packed {
        logic               en;
        logic [LEN_W-1:0]   base;
        logic [3:0]         count;
    } lane_wr_t;

endpackage

// ----- rtl/fragment_reassembly_buffer.sv -----
// Fragment reassembly buffer: top level with readout sequencer and output register.
// Depends on frb_pkg, frb_ctrl, frb_lane and frb_merge.
//
// Usage:
//   s_ channel carries fragments (offset, announced total, byte count, data).
//   m_ channel carries results: m_tuser gives the kind (pending, complete word,
//   dropped), m_tlast marks the final result caused by a fragment.
//   cfg_we/cfg_wdata write the largest stored message length; write only while idle.
// Latency and throughput:
//   A fragment that does not complete a message is checked combinationally, and
//   its result is in the output register in the cycle after it is taken; such
//   fragments flow at one per cycle while the receiver keeps m_tready high.
//   A completing fragment starts a readout of ceil(len/8) words; each word is a
//   registered read of the eight byte lanes, then the output load, and no
//   fragment is accepted until the last word is loaded.
// Reset: aresetn low clears the message state, the readout sequencer and the
//   output valid; the limit returns to 512. The byte store is not cleared.
// Stall: when m_tready is low the output holds, and s_tready and the readout
//   wait until the word is taken.
module fragment_reassembly_buffer #(
    parameter int STORE_BYTES = 512,
    parameter int LANE_BYTES  = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    // configuration
    input  logic            cfg_we,
    input  logic [9:0]      cfg_wdata,
    // fragments in
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [135:0]    s_tdata,   // frag_offset[31:0], total_len[63:32],
                                       // chunk_bytes[67:64], chunk_data[131:68], zero pad
    // results out
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [79:0]     m_tdata,   // msg_len[9:0], word_data[73:10],
                                       // word_index[79:74]
    output logic [1:0]      m_tuser,   // status[1:0]
    output logic            m_tlast
);
    import frb_pkg::*;

    localparam int STORE_LIM = (STORE_BYTES < READ_LIMIT) ? STORE_BYTES : READ_LIMIT;
    localparam int ROWS      = (STORE_LIM + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;

    rd_state_t          state_reg, state_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [LEN_W-1:0]   rd_len_reg, rd_len_next;

    logic               m_tvalid_reg, m_tvalid_next;
    status_t            m_status_reg, m_status_next;
    logic [LEN_W-1:0]   m_len_reg, m_len_next;
    logic [63:0]        m_data_reg, m_data_next;
    logic [IDX_W-1:0]   m_idx_reg, m_idx_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic               accept;
    logic               rd_en;
    frag_res_t          res;
    lane_wr_t           wr;
    logic [7:0]         lane_byte [WORD_BYTES];
    logic [63:0]        merged;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == RS_ACCEPT) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Fragment checks
    frb_ctrl #(
        .LANE_BYTES  (LANE_BYTES),
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .accept      (accept),
        .frag_offset (s_tdata[31:0]),
        .total_len   (s_tdata[63:32]),
        .chunk_bytes (s_tdata[67:64]),
        .res         (res),
        .wr          (wr)
    );

    // Byte lanes
    for (genvar k = 0; k < WORD_BYTES; k++) begin : g_lane
        frb_lane #(
            .LANE (k),
            .ROWS (ROWS),
            .RW   (RW)
        ) u_lane (
            .aclk       (aclk),
            .wr         (accept ? wr : '0),
            .chunk_data (s_tdata[131:68]),
            .rd_en      (rd_en),
            .rd_row     (rd_idx_reg[RW-1:0]),
            .rd_byte    (lane_byte[k])
        );
    end

    // Word assembly
    frb_merge u_merge (
        .lane_byte (lane_byte),
        .word_idx  (rd_idx_reg),
        .msg_len   (rd_len_reg),
        .word      (merged)
    );

    // Readout sequencer and output register loading
    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        last_idx_next = last_idx_reg;
        rd_len_next   = rd_len_reg;
        rd_en         = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_len_next    = m_len_reg;
        m_data_next   = m_data_reg;
        m_idx_next    = m_idx_reg;
        m_last_next   = m_last_reg;
        unique case (state_reg)
            RS_ACCEPT: begin
                if (accept) begin
                    if (res.status == STATUS_COMPLETE) begin
                        state_next    = RS_ADDR;
                        rd_idx_next   = '0;
                        last_idx_next = res.last_idx;
                        rd_len_next   = res.msg_len;
                    end else begin
                        m_tvalid_next = 1'b1;
                        m_status_next = res.status;
                        m_len_next    = '0;
                        m_data_next   = 64'd0;
                        m_idx_next    = '0;
                        m_last_next   = 1'b1;
                    end
                end
            end
            RS_ADDR: begin
                rd_en      = 1'b1;
                state_next = RS_DATA;
            end
            RS_DATA: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = STATUS_COMPLETE;
                    m_len_next    = rd_len_reg;
                    m_data_next   = merged;
                    m_idx_next    = rd_idx_reg;
                    m_last_next   = (rd_idx_reg == last_idx_reg);
                    if (rd_idx_reg == last_idx_reg) begin
                        state_next = RS_ACCEPT;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        state_next  = RS_ADDR;
                    end
                end
            end
            default: begin
                state_next = RS_ACCEPT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= RS_ACCEPT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        last_idx_reg <= last_idx_next;
        rd_len_reg   <= rd_len_next;
        m_status_reg <= m_status_next;
        m_len_reg    <= m_len_next;
        m_data_reg   <= m_data_next;
        m_idx_reg    <= m_idx_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_idx_reg, m_data_reg, m_len_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/frb_ctrl.sv -----
// Fragment checks and message state: offset, total and length tracking.
// Depends on frb_pkg.
module frb_ctrl #(
    parameter int LANE_BYTES  = 8,
    parameter int STORE_BYTES = 512
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [9:0]              cfg_wdata,
    input  logic                    accept,
    input  logic [31:0]             frag_offset,
    input  logic [31:0]             total_len,
    input  logic [3:0]              chunk_bytes,
    output frb_pkg::frag_res_t      res,
    output frb_pkg::lane_wr_t       wr
);
    import frb_pkg::*;

    localparam int STORE_LIM = (STORE_BYTES < READ_LIMIT) ? STORE_BYTES : READ_LIMIT;

    logic [LEN_W-1:0] max_len_reg;
    logic [31:0]      bytes_rx_reg, bytes_rx_next;
    logic [31:0]      exp_len_reg, exp_len_next;
    logic             discard_reg, discard_next;

    logic [3:0]       n;
    logic             start;
    logic [31:0]      tot;
    logic [LEN_W-1:0] limit;
    logic [31:0]      exp_eff;
    logic [31:0]      br_eff;
    logic             disc_eff;
    logic             bad_cont;
    logic [32:0]      sum;
    logic [LEN_W-1:0] len_m1;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_W'(READ_LIMIT);
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    // Effective storage limit
    always_comb begin
        if (max_len_reg > LEN_W'(STORE_LIM)) begin
            limit = LEN_W'(STORE_LIM);
        end else begin
            limit = max_len_reg;
        end
    end

    // Fragment decode
    always_comb begin
        n        = (chunk_bytes > 4'(LANE_BYTES)) ? 4'(LANE_BYTES) : chunk_bytes;
        start    = (frag_offset == 32'd0);
        tot      = (total_len == 32'd0) ? {28'd0, n} : total_len;
        exp_eff  = start ? tot : exp_len_reg;
        br_eff   = start ? 32'd0 : bytes_rx_reg;
        disc_eff = start ? (tot > {22'd0, limit}) : discard_reg;
        bad_cont = !start && ((exp_len_reg == 32'd0) || (total_len != exp_len_reg)
                              || (frag_offset != bytes_rx_reg));
        sum      = {1'b0, br_eff} + {29'd0, n};
        len_m1   = sum[LEN_W-1:0] - LEN_W'(1);
    end

    // Outcome and next state
    always_comb begin
        bytes_rx_next = 32'd0;
        exp_len_next  = 32'd0;
        discard_next  = 1'b0;
        res.status    = STATUS_PENDING;
        res.msg_len   = '0;
        res.last_idx  = len_m1[IDX_W+2:3];
        wr.en         = 1'b0;
        wr.base       = br_eff[LEN_W-1:0];
        wr.count      = n;
        priority if (start && (tot == 32'd0)) begin
            res.status = STATUS_PENDING;
        end else if (bad_cont) begin
            res.status = STATUS_DROPPED;
        end else if (sum > {1'b0, exp_eff}) begin
            // overrun of the announced total
            res.status = STATUS_DROPPED;
        end else if (sum < {1'b0, exp_eff}) begin
            res.status    = STATUS_PENDING;
            wr.en         = !disc_eff;
            bytes_rx_next = sum[31:0];
            exp_len_next  = exp_eff;
            discard_next  = disc_eff;
        end else begin
            // final fragment
            wr.en = !disc_eff;
            if (disc_eff) begin
                res.status = STATUS_DROPPED;
            end else begin
                res.status  = STATUS_COMPLETE;
                res.msg_len = sum[LEN_W-1:0];
            end
        end
    end

    // Message state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_rx_reg <= 32'd0;
            exp_len_reg  <= 32'd0;
            discard_reg  <= 1'b0;
        end else if (accept) begin
            bytes_rx_reg <= bytes_rx_next;
            exp_len_reg  <= exp_len_next;
            discard_reg  <= discard_next;
        end
    end

endmodule

// ----- rtl/frb_lane.sv -----
// One byte lane: a byte-wide bank holding every eighth message byte.
// Depends on frb_pkg.
module frb_lane #(
    parameter int LANE = 0,
    parameter int ROWS = 64,
    parameter int RW   = 6
) (
    input  logic                    aclk,
    input  frb_pkg::lane_wr_t       wr,
    input  logic [63:0]             chunk_data,
    input  logic                    rd_en,
    input  logic [RW-1:0]           rd_row,
    output logic [7:0]              rd_byte
);
    import frb_pkg::*;

    logic [7:0]       mem [ROWS];
    logic [7:0]       rd_byte_reg;
    logic [2:0]       sel;
    logic             hit;
    logic [LEN_W-1:0] addr;
    logic [6:0]       row;
    logic [7:0]       wbyte;

    // Which chunk byte lands in this lane, and where
    always_comb begin
        sel   = 3'(LANE) - wr.base[2:0];
        hit   = wr.en && ({1'b0, sel} < wr.count);
        addr  = wr.base + {7'd0, sel};
        row   = addr[LEN_W-1:3];
        wbyte = chunk_data[8*sel +: 8];
    end

    // Bank write and registered read
    always_ff @(posedge aclk) begin
        if (hit && (row < 7'(ROWS))) begin
            mem[row[RW-1:0]] <= wbyte;
        end
        if (rd_en) begin
            rd_byte_reg <= mem[rd_row];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

// ----- rtl/frb_merge.sv -----
// Merges the lane bytes into one readout word, zeroing bytes past the end.
// Depends on frb_pkg.
module frb_merge (
    input  logic [7:0]                  lane_byte [frb_pkg::WORD_BYTES],
    input  logic [frb_pkg::IDX_W-1:0]   word_idx,
    input  logic [frb_pkg::LEN_W-1:0]   msg_len,
    output logic [63:0]                 word
);
    import frb_pkg::*;

    always_comb begin
        for (int k = 0; k < WORD_BYTES; k++) begin
            if ({1'b0, word_idx, 3'(k)} < msg_len) begin
                word[8*k +: 8] = lane_byte[k];
            end else begin
                word[8*k +: 8] = 8'd0;
            end
        end
    end

endmodule

// ----- rtl/frb_checker.sv -----
// Port-level checks for the fragment reassembly buffer, bound to the top level.
// Depends on frb_pkg and fragment_reassembly_buffer.
module frb_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tready,
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  logic [79:0]     m_tdata,
    input  logic [1:0]      m_tuser,
    input  logic            m_tlast
);
    import frb_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // No fragment is taken while a result would be lost
    a_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready with output blocked");

    // Pending and dropped results are single, all-zero transfers
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STATUS_COMPLETE) |->
            m_tlast && (m_tdata == 80'd0) && (m_tuser == STATUS_PENDING
            || m_tuser == STATUS_DROPPED))
        else $error("bad single result");

    // The last word of a message sits at index (len-1)/8
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STATUS_COMPLETE) && m_tlast |->
            (m_tdata[79:74] == 6'((m_tdata[9:0] - 10'd1) >> 3)) && (m_tdata[9:0] != 10'd0))
        else $error("last word index does not match length");

endmodule

bind fragment_reassembly_buffer frb_checker u_frb_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench for fragment_reassembly_buffer: a directed table, then random fragment streams
// under several length limits, each result checked against a reassembly model or a typed-in result.
// Depends on frb_pkg and the fragment_reassembly_buffer RTL.
module tb;
    import frb_pkg::*;

    localparam int STORE_SZ    = 512;
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int WATCHDOG    = 3000;  // cycles with no transfer or register write

    typedef struct {
        status_t     status;
        logic [9:0]  msg_len;
        logic [63:0] word;
        logic [5:0]  index;
        logic        last;
    } result_t;

    typedef struct {
        logic [31:0] offset;
        logic [31:0] total;
        logic [3:0]  nbytes;
        logic [63:0] data;
        bit          typed;    // result typed in below, not taken from the model
        status_t     status;
    } frag_row_t;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [9:0]     cfg_wdata = '0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [135:0]   s_tdata   = '0;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [79:0]    m_tdata;
    logic [1:0]     m_tuser;
    logic           m_tlast;

    // travel alongside s_tdata so the monitor knows how to predict the transfer
    bit             row_typed  = 1'b0;
    status_t        row_status = STATUS_PENDING;

    // model state
    logic [9:0]     limit_reg = 10'd512;
    logic [31:0]    rx_count  = '0;
    logic [31:0]    msg_total = '0;
    bit             discarding = 1'b0;
    logic [7:0]     msg_bytes [STORE_SZ];

    result_t        frag_out[$];     // results of the fragment just taken
    result_t        due_results[$];  // results still to come from the block

    int             errors = 0;
    int             n_sent = 0;
    int             stalled_cycles = 0;
    bit             s_quiet = 1'b0;
    bit             m_quiet = 1'b0;
    bit             hold_req = 1'b0;

    frag_row_t directed_rows [25] = '{
        '{32'd0, 32'd0, 4'd0, 64'h0, 1'b1, STATUS_PENDING},             // empty start
        '{32'd5, 32'd10, 4'd8, 64'hDEAD_BEEF_0000_0001, 1'b1, STATUS_DROPPED}, // stray
        '{32'd0, 32'd0, 4'd8, 64'h0123_4567_89AB_CDEF, 1'b0, STATUS_PENDING},
        '{32'd0, 32'd0, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STATUS_PENDING}, // partial word
        '{32'd0, 32'd0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, STATUS_PENDING}, // oversize count
        '{32'd0, 32'd20, 4'd8, 64'h1111_1111_1111_1111, 1'b1, STATUS_PENDING},
        '{32'd8, 32'd20, 4'd8, 64'h2222_2222_2222_2222, 1'b1, STATUS_PENDING},
        '{32'd16, 32'd20, 4'd4, 64'h3333_3333_4444_4444, 1'b0, STATUS_PENDING},
        '{32'd0, 32'd16, 4'd8, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, STATUS_PENDING},
        '{32'd8, 32'd17, 4'd8, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1, STATUS_DROPPED}, // total changed
        '{32'd0, 32'd16, 4'd8, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, STATUS_PENDING},
        '{32'd4, 32'd16, 4'd8, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1, STATUS_DROPPED}, // bad offset
        '{32'd0, 32'd10, 4'd8, 64'h0102_0304_0506_0708, 1'b1, STATUS_PENDING},
        '{32'd8, 32'd10, 4'd8, 64'h0910_1112_1314_1516, 1'b1, STATUS_DROPPED}, // overrun
        '{32'd0, 32'd4, 4'd8, 64'h0102_0304_0506_0708, 1'b1, STATUS_DROPPED},  // overrun at start
        '{32'd0, 32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, STATUS_PENDING},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8, 64'h0, 1'b1, STATUS_DROPPED},
        '{32'd0, 32'd16, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, STATUS_PENDING},
        '{32'd0, 32'd0, 4'd2, 64'h5555_5555_5555_5555, 1'b0, STATUS_PENDING}, // restart
        '{32'd0, 32'd24, 4'd0, 64'h0, 1'b1, STATUS_PENDING},
        '{32'd0, 32'd24, 4'd8, 64'h8877_6655_4433_2211, 1'b1, STATUS_PENDING},
        '{32'd8, 32'd24, 4'd0, 64'hFFFF_0000_FFFF_0000, 1'b1, STATUS_PENDING}, // no bytes
        '{32'd8, 32'd24, 4'd8, 64'h0000_FFFF_0000_FFFF, 1'b1, STATUS_PENDING},
        '{32'd16, 32'd24, 4'd8, 64'hFEDC_BA98_7654_3210, 1'b0, STATUS_PENDING},
        '{32'd24, 32'd24, 4'd1, 64'h0, 1'b1, STATUS_DROPPED}                 // nothing open
    };

    fragment_reassembly_buffer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ---------------- model ----------------

    function automatic void clear_message();
        rx_count   = '0;
        msg_total  = '0;
        discarding = 1'b0;
    endfunction

    function automatic void push_single(status_t st);
        frag_out.push_back('{st, 10'd0, 64'd0, 6'd0, 1'b1});
    endfunction

    // Works out the results one fragment causes and advances the message state
    function automatic void reassemble(logic [31:0] offset, logic [31:0] total,
                                       logic [3:0] nb, logic [63:0] data);
        logic [31:0] n;
        logic [31:0] len;
        logic [31:0] lim;
        logic [63:0] word;
        int          words;
        frag_out.delete();
        n   = (nb > WORD_BYTES) ? WORD_BYTES : nb;
        lim = (limit_reg > READ_LIMIT) ? READ_LIMIT : limit_reg;
        if (offset == 0) begin
            clear_message();
            if (total == 0) total = n;
            if (total == 0) begin
                push_single(STATUS_PENDING);
                return;
            end
            msg_total = total;
            if (total > lim) discarding = 1'b1;
        end else if (msg_total == 0 || total != msg_total || offset != rx_count) begin
            clear_message();
            push_single(STATUS_DROPPED);
            return;
        end
        if (n > msg_total - rx_count) begin
            clear_message();
            push_single(STATUS_DROPPED);
            return;
        end
        if (!discarding) begin
            for (int i = 0; i < n; i++)
                if (rx_count + i < STORE_SZ) msg_bytes[rx_count + i] = data[8*i +: 8];
        end
        rx_count = rx_count + n;
        if (rx_count < msg_total) begin
            push_single(STATUS_PENDING);
            return;
        end
        len = rx_count;
        if (discarding) begin
            clear_message();
            push_single(STATUS_DROPPED);
            return;
        end
        clear_message();
        // readout: bytes past the message length read as zero
        words = (len + 7) / 8;
        for (int w = 0; w < words; w++) begin
            word = '0;
            for (int i = 0; i < 8; i++)
                if (w * 8 + i < len) word[8*i +: 8] = msg_bytes[w * 8 + i];
            frag_out.push_back('{STATUS_COMPLETE, len[9:0], word, 6'(w), w == words - 1});
        end
    endfunction

    // ---------------- checking ----------------

    task automatic check_result();
        result_t e;
        if (due_results.size() == 0) begin
            $error("result with none expected: status %0d, len %0d", m_tuser, m_tdata[9:0]);
            errors++;
            return;
        end
        e = due_results.pop_front();
        if (m_tuser !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, m_tuser);
            errors++;
        end
        if (m_tdata[9:0] !== e.msg_len) begin
            $error("msg_len: expected %0d, got %0d", e.msg_len, m_tdata[9:0]);
            errors++;
        end
        if (m_tdata[73:10] !== e.word) begin
            $error("word_data: expected %h, got %h", e.word, m_tdata[73:10]);
            errors++;
        end
        if (m_tdata[79:74] !== e.index) begin
            $error("word_index: expected %0d, got %0d", e.index, m_tdata[79:74]);
            errors++;
        end
        if (m_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_tlast);
            errors++;
        end
    endtask

    // Monitor: register writes, fragment transfers and result transfers, all sampled at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) limit_reg = cfg_wdata;
            if (s_tvalid && s_tready) begin
                reassemble(s_tdata[31:0], s_tdata[63:32], s_tdata[67:64], s_tdata[131:68]);
                if (row_typed) due_results.push_back('{row_status, 10'd0, 64'd0, 6'd0, 1'b1});
                else foreach (frag_out[i]) due_results.push_back(frag_out[i]);
            end
            if (m_tvalid && m_tready) check_result();
        end
    end

    // Watchdog on cycles with no transfer of any kind and no register write
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles == WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // ---------------- result side ----------------

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = m_quiet ? 0 : $urandom_range(0, 17);
                if ($urandom_range(0, 31) == 0) m_quiet = !m_quiet;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ---------------- fragment side ----------------

    task automatic send_frag(logic [31:0] offset, logic [31:0] total, logic [3:0] nb,
                             logic [63:0] data, bit typed = 1'b0,
                             status_t st = STATUS_PENDING);
        int gap;
        gap = s_quiet ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 31) == 0) s_quiet = !s_quiet;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {4'b0, data, nb, total, offset};
        row_typed  <= typed;
        row_status <= st;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    // One message in random pieces; if spoilt, one fragment may be broken and the rest abandoned
    task automatic send_message(int len, bit spoil);
        int          pos;
        int          n;
        int          frag_no;
        int          cut;
        logic [3:0]  nfield;
        logic [31:0] offset;
        logic [31:0] total;
        pos     = 0;
        frag_no = 0;
        cut     = spoil ? $urandom_range(1, 3) : -1;
        while (pos < len) begin
            n = $urandom_range(0, WORD_BYTES);
            if (n > len - pos) n = len - pos;
            nfield = 4'(n);
            if (n == WORD_BYTES && $urandom_range(0, 3) == 0) nfield = 4'($urandom_range(9, 15));
            offset = pos;
            total  = len;
            if (pos == 0 && n == len && $urandom_range(0, 1) == 0) total = '0;
            if (frag_no == cut) begin
                case ($urandom_range(0, 2))
                    0: begin
                        total = len ^ (32'd1 << $urandom_range(0, 31));
                    end
                    1: begin
                        offset = pos ^ (32'd1 << $urandom_range(0, 31));
                    end
                    default: begin
                        nfield = (len - pos + 1 > 15) ? 4'd15 : 4'(len - pos + 1);
                    end
                endcase
            end
            send_frag(offset, total, nfield, {$urandom, $urandom});
            if (frag_no == cut) return;
            pos += n;
            frag_no++;
        end
    endtask

    task automatic run_traffic(int n_items, int max_len);
        int stop;
        int pick;
        int len;
        stop = n_sent + n_items;
        while (n_sent < stop) begin
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, max_len)
                                               : $urandom_range(1, 24);
            if (pick < 7) begin
                send_message(len, 1'b0);
            end else if (pick < 9) begin
                send_message(len, 1'b1);
            end else begin
                send_frag(($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom), $urandom,
                          4'($urandom_range(0, 15)), {$urandom, $urandom});
            end
        end
    endtask

    // Let every result drain, then write the length limit
    task automatic set_limit(logic [9:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // ---------------- sequence ----------------

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table at the reset limit
        foreach (directed_rows[i])
            send_frag(directed_rows[i].offset, directed_rows[i].total, directed_rows[i].nbytes,
                      directed_rows[i].data, directed_rows[i].typed, directed_rows[i].status);

        // limits 0, 1, 9; at 0 nothing is stored: a nonempty message drops on its last fragment
        set_limit(10'd0);
        run_traffic(10, 24);
        set_limit(10'd1);
        run_traffic(10, 24);
        set_limit(10'd9);
        run_traffic(15, 24);

        // top of the register; a full 512-byte message reads out all 64 words
        set_limit(10'd1023);
        for (int k = 0; k < 64; k++)
            send_frag(32'(8 * k), 32'd512, 4'd8, {$urandom, $urandom});
        run_traffic(10, 64);

        // receiver holds off while fragments keep coming
        set_limit(10'd40);
        hold_req = 1'b1;
        run_traffic(15, 64);

        set_limit(10'($urandom_range(0, 1023)));
        run_traffic(15, 64);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- fragment_reassembly_buffer.f -----
rtl/frb_pkg.sv
rtl/frb_ctrl.sv
rtl/frb_lane.sv
rtl/frb_merge.sv
rtl/fragment_reassembly_buffer.sv
rtl/frb_checker.sv
verif/tb.sv
